// ----- rtl/core/scl_pkg.sv -----
package scl_pkg;

    // Command bytes received on the serial line while idle.
    localparam logic [7:0] CMD_LOAD_BASE  = 8'h80;
    localparam logic [7:0] CMD_SEND_SUM   = 8'h81;
    localparam logic [7:0] CMD_SET_LEN    = 8'h90;
    localparam logic [7:0] CMD_SET_SUM    = 8'h91;
    localparam logic [7:0] CMD_WRITE_BLK  = 8'hA0;
    localparam logic [7:0] CMD_READ_BLK   = 8'hA1;
    localparam logic [7:0] CMD_SET_BAUD   = 8'hB0;
    localparam logic [7:0] CMD_JUMP       = 8'hB1;

    // Result kinds.
    localparam logic [2:0] KIND_TX    = 3'd0;
    localparam logic [2:0] KIND_WRITE = 3'd1;
    localparam logic [2:0] KIND_READ  = 3'd2;
    localparam logic [2:0] KIND_BAUD  = 3'd3;
    localparam logic [2:0] KIND_JUMP  = 3'd4;

    // Source of an input byte.
    localparam logic OP_SERIAL = 1'b0;
    localparam logic OP_MEMORY = 1'b1;

    // Baud rates and the divisor codes that go with them.
    localparam logic [31:0] BAUD_3000000 = 32'd3000000;
    localparam logic [31:0] BAUD_1000000 = 32'd1000000;
    localparam logic [31:0] BAUD_921600  = 32'd921600;
    localparam logic [3:0]  CODE_3000000 = 4'd15;
    localparam logic [3:0]  CODE_1000000 = 4'd13;
    localparam logic [3:0]  CODE_921600  = 4'd12;
    localparam logic [3:0]  CODE_DEFAULT = 4'd9;

    // Most results one input byte can cause.
    localparam int RES_MAX = 4;
    localparam int RES_CNT_W = 3;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_BASE,
        MODE_WRITE,
        MODE_READ,
        MODE_DONE
    } t_mode;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] address;
        logic [7:0]  byte_value;
        logic [3:0]  baud_code;
        logic        last;
    } t_result;

    function automatic t_result make_result(
        input logic [2:0]  kind,
        input logic [31:0] address,
        input logic [7:0]  byte_value,
        input logic [3:0]  baud_code
    );
        t_result res;
        res.kind       = kind;
        res.address    = address;
        res.byte_value = byte_value;
        res.baud_code  = baud_code;
        res.last       = 1'b0;
        return res;
    endfunction

endpackage

// ----- rtl/core/scl_engine.sv -----
module scl_engine
    import scl_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_take,
    input  logic                         i_op,
    input  logic [7:0]                   i_data,
    output t_result [RES_MAX-1:0]        o_results,
    output logic [RES_CNT_W-1:0]         o_count
);

    t_mode       r_mode, n_mode;
    logic [31:0] r_base, n_base;
    logic [31:0] r_len, n_len;
    logic [31:0] r_sum, n_sum;
    logic [31:0] r_idx, n_idx;
    logic [1:0]  r_seen, n_seen;

    logic [31:0] idx_inc;
    logic        blk_done;
    logic [31:0] sum_step;
    logic [3:0]  baud_sel;
    t_result [RES_MAX-1:0] res;
    logic [RES_CNT_W-1:0]  cnt;

    assign idx_inc  = r_idx + 32'd1;
    assign blk_done = (idx_inc == r_len);
    assign sum_step = {r_sum[30:0], r_sum[31]} + {24'd0, i_data};

    always_comb begin
        if (r_base == BAUD_3000000) begin
            baud_sel = CODE_3000000;
        end else if (r_base == BAUD_1000000) begin
            baud_sel = CODE_1000000;
        end else if (r_base == BAUD_921600) begin
            baud_sel = CODE_921600;
        end else begin
            baud_sel = CODE_DEFAULT;
        end
    end

    // Next mode.
    always_comb begin
        n_mode = r_mode;
        if (i_take) begin
            case (r_mode)
                MODE_IDLE: begin
                    if (i_op == OP_SERIAL) begin
                        case (i_data)
                            CMD_LOAD_BASE: n_mode = MODE_BASE;
                            CMD_WRITE_BLK: n_mode = (r_len != 32'd0) ? MODE_WRITE : MODE_IDLE;
                            CMD_READ_BLK:  n_mode = (r_len != 32'd0) ? MODE_READ : MODE_IDLE;
                            CMD_JUMP:      n_mode = MODE_DONE;
                            default:       n_mode = MODE_IDLE;
                        endcase
                    end
                end
                MODE_BASE: begin
                    if (i_op == OP_SERIAL && r_seen == 2'd3) begin
                        n_mode = MODE_IDLE;
                    end
                end
                MODE_WRITE: begin
                    if (i_op == OP_SERIAL && blk_done) begin
                        n_mode = MODE_IDLE;
                    end
                end
                MODE_READ: begin
                    if (i_op == OP_MEMORY && blk_done) begin
                        n_mode = MODE_IDLE;
                    end
                end
                default: n_mode = r_mode;
            endcase
        end
    end

    // Datapath updates and results.
    always_comb begin
        n_base = r_base;
        n_len  = r_len;
        n_sum  = r_sum;
        n_idx  = r_idx;
        n_seen = r_seen;
        cnt    = '0;
        for (int i = 0; i < RES_MAX; i++) begin
            res[i] = make_result(KIND_TX, 32'd0, 8'd0, 4'd0);
        end
        if (i_take) begin
            case (r_mode)
                MODE_IDLE: begin
                    if (i_op == OP_SERIAL) begin
                        case (i_data)
                            CMD_LOAD_BASE: n_seen = 2'd0;
                            CMD_SEND_SUM: begin
                                res[0] = make_result(KIND_TX, 32'd0, r_sum[31:24], 4'd0);
                                res[1] = make_result(KIND_TX, 32'd0, r_sum[23:16], 4'd0);
                                res[2] = make_result(KIND_TX, 32'd0, r_sum[15:8], 4'd0);
                                res[3] = make_result(KIND_TX, 32'd0, r_sum[7:0], 4'd0);
                                cnt    = RES_CNT_W'(4);
                            end
                            CMD_SET_LEN: n_len = r_base;
                            CMD_SET_SUM: n_sum = r_base;
                            CMD_WRITE_BLK: begin
                                n_sum = 32'd0;
                                n_idx = 32'd0;
                            end
                            CMD_READ_BLK: begin
                                n_sum = 32'd0;
                                n_idx = 32'd0;
                                if (r_len != 32'd0) begin
                                    res[0] = make_result(KIND_READ, r_base, 8'd0, 4'd0);
                                    cnt    = RES_CNT_W'(1);
                                end
                            end
                            CMD_SET_BAUD: begin
                                res[0] = make_result(KIND_BAUD, 32'd0, 8'd0, baud_sel);
                                cnt    = RES_CNT_W'(1);
                            end
                            CMD_JUMP: begin
                                res[0] = make_result(KIND_JUMP, r_base, 8'd0, 4'd0);
                                cnt    = RES_CNT_W'(1);
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                MODE_BASE: begin
                    if (i_op == OP_SERIAL) begin
                        n_base = {r_base[23:0], i_data};
                        n_seen = r_seen + 2'd1;
                    end
                end
                MODE_WRITE: begin
                    if (i_op == OP_SERIAL) begin
                        n_sum  = sum_step;
                        n_idx  = idx_inc;
                        res[0] = make_result(KIND_WRITE, r_base + r_idx, i_data, 4'd0);
                        cnt    = RES_CNT_W'(1);
                    end
                end
                MODE_READ: begin
                    if (i_op == OP_MEMORY) begin
                        n_sum  = sum_step;
                        n_idx  = idx_inc;
                        res[0] = make_result(KIND_TX, 32'd0, i_data, 4'd0);
                        cnt    = RES_CNT_W'(1);
                        if (!blk_done) begin
                            res[1] = make_result(KIND_READ, r_base + idx_inc, 8'd0, 4'd0);
                            cnt    = RES_CNT_W'(2);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        // Flag the final result of this byte.
        for (int i = 0; i < RES_MAX; i++) begin
            res[i].last = (RES_CNT_W'(i + 1) == cnt);
        end
    end

    assign o_results = res;
    assign o_count   = cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_base <= '0;
            r_len  <= '0;
            r_sum  <= '0;
            r_idx  <= '0;
            r_seen <= '0;
        end else begin
            r_mode <= n_mode;
            r_base <= n_base;
            r_len  <= n_len;
            r_sum  <= n_sum;
            r_idx  <= n_idx;
            r_seen <= n_seen;
        end
    end

endmodule

// ----- rtl/core/scl_out_buf.sv -----
module scl_out_buf
    import scl_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  t_result [RES_MAX-1:0]        i_results,
    input  logic [RES_CNT_W-1:0]         i_count,
    input  logic                         i_ready,
    output logic                         o_can_load,
    output logic                         o_valid,
    output t_result                      o_result
);

    t_result [RES_MAX-1:0] r_buf;
    logic [RES_CNT_W-1:0]  r_cnt, n_cnt;
    logic                  take;

    assign o_valid  = (r_cnt != '0);
    assign take     = o_valid && i_ready;
    // A new batch may load once the last buffered result leaves.
    assign o_can_load = (r_cnt == '0) || (r_cnt == RES_CNT_W'(1) && i_ready);
    assign o_result = r_buf[0];

    always_comb begin
        n_cnt = r_cnt;
        if (i_load) begin
            n_cnt = i_count;
        end else if (take) begin
            n_cnt = r_cnt - RES_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf <= i_results;
        end else if (take) begin
            for (int i = 0; i < RES_MAX - 1; i++) begin
                r_buf[i] <= r_buf[i + 1];
            end
        end
    end

endmodule

// ----- rtl/core/serial_command_loader.sv -----
// An accepted byte waits in the input register until the output buffer can
// load; its results are then registered in that buffer. One byte per cycle
// is taken while each byte causes at most one result and the output is ready;
// a byte with more results (up to four) holds the next until its last leaves.
// Reset (synchronous, active low) returns to idle, clears base, length,
// checksum and index, and drops any byte or result still held.
module serial_command_loader
    import scl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data
    input  logic        i_s_axis_tuser,   // [0] op
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // [31:0] address, [39:32] byte_value,
                                          // [43:40] baud_code, [47:44] zero
    output logic [2:0]  o_m_axis_tuser,   // [2:0] kind
    output logic        o_m_axis_tlast
);

    logic                  r_in_valid;
    logic                  r_in_op;
    logic [7:0]            r_in_data;
    logic                  eng_take;
    logic                  can_load;
    t_result [RES_MAX-1:0] results;
    logic [RES_CNT_W-1:0]  count;
    t_result               out_res;

    assign eng_take        = r_in_valid && can_load;
    assign o_s_axis_tready = !r_in_valid || eng_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_op   <= i_s_axis_tuser;
            r_in_data <= i_s_axis_tdata;
        end
    end

    scl_engine u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (eng_take),
        .i_op      (r_in_op),
        .i_data    (r_in_data),
        .o_results (results),
        .o_count   (count)
    );

    scl_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (eng_take),
        .i_results  (results),
        .i_count    (count),
        .i_ready    (i_m_axis_tready),
        .o_can_load (can_load),
        .o_valid    (o_m_axis_tvalid),
        .o_result   (out_res)
    );

    assign o_m_axis_tdata = {4'd0, out_res.baud_code, out_res.byte_value, out_res.address};
    assign o_m_axis_tuser = out_res.kind;
    assign o_m_axis_tlast = out_res.last;

endmodule
